[rtl/sha256_stream_hasher_top_macros.svh]
// Assertion macros for the checker file.
`ifndef SHA256_STREAM_HASHER_TOP_MACROS_SVH
`define SHA256_STREAM_HASHER_TOP_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define SHS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define SHS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[rtl/shs_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-256 stream hasher package
// Round constants, initial hash values and the controller/datapath types.
// ----------------------------------------------------------------------------
`default_nettype none
package shs_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_number;
        logic        last_word;
        logic        len_overflow;
    } out_item_t;

    // Source of the byte written into the block buffer.
    localparam logic [1:0] BSEL_DATA = 2'd0;
    localparam logic [1:0] BSEL_PAD  = 2'd1;
    localparam logic [1:0] BSEL_ZERO = 2'd2;
    localparam logic [1:0] BSEL_LEN  = 2'd3;

    typedef struct packed {
        logic       wr_byte;     // write one byte at the fill pointer
        logic [1:0] byte_sel;
        logic       count_byte;  // advance the message length
        logic       comp_start;  // load working vars from hash words
        logic       comp_round;  // run one round
        logic       comp_fold;   // add working vars into hash words
        logic       restart;     // reinitialize for the next message
        logic       out_load;    // load digest word into the output register
        logic [2:0] out_index;
    } shs_cmd_t;

    typedef struct packed {
        logic [5:0] fill_level;
        logic [5:0] round_index;
    } shs_status_t;

    localparam logic [31:0] INITIAL_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
        32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
        32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
        32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
        32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
        32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
        32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
        32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
        32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;
    localparam logic [60:0] MAX_BYTES = {61{1'b1}};

endpackage
`default_nettype wire

[rtl/shs_stream_if.sv]
// ----------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one payload word of type T.
// ----------------------------------------------------------------------------
`default_nettype none
interface shs_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[rtl/shs_datapath.sv]
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block buffer, message schedule window, round unit, hash words and length.
// ----------------------------------------------------------------------------
`default_nettype none
module shs_datapath (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [7:0]      data_byte,
    input  shs_pkg::shs_cmd_t    cmd,
    output shs_pkg::shs_status_t status,
    output shs_pkg::out_item_t   out_item
);
    import shs_pkg::*;

    logic [31:0] block_mem [16];
    logic [31:0] rd_word_reg;
    logic [3:0]  rd_addr;
    logic [31:0] w_reg [16];
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [60:0] count_reg;
    logic        too_long_reg;
    logic [5:0]  fill_reg;
    logic [5:0]  round_reg;
    logic [7:0]  wr_data;
    logic [31:0] w_cur, w_new, s0, s1, t1, t2, e, a;
    logic [63:0] bits;
    logic [2:0]  len_idx;

    assign status.fill_level  = fill_reg;
    assign status.round_index = round_reg;

    // Byte selection for the buffer write.
    assign bits    = {count_reg, 3'b000};
    assign len_idx = 3'(~fill_reg[2:0]);
    always_comb
    begin
        case (cmd.byte_sel)
            BSEL_DATA: wr_data = data_byte;
            BSEL_PAD:  wr_data = PAD_BYTE;
            BSEL_ZERO: wr_data = 8'h00;
            BSEL_LEN:  wr_data = bits[{len_idx, 3'b000} +: 8];
            default:   wr_data = 8'h00;
        endcase
    end

    // Block buffer memory: four bytes per entry, first byte in the top lane.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_byte)
        begin
            block_mem[fill_reg[5:2]][{~fill_reg[1:0], 3'b000} +: 8] <= wr_data;
        end
    end

    // Registered read, one entry ahead of the round that uses it.
    assign rd_addr = cmd.comp_start ? 4'd0 : (round_reg[3:0] + 4'd1);
    always_ff @(posedge clk)
    begin
        rd_word_reg <= block_mem[rd_addr];
    end

    // Schedule: the first 16 rounds read the buffer, later rounds extend it.
    assign s0 = {w_reg[1][6:0], w_reg[1][31:7]} ^ {w_reg[1][17:0], w_reg[1][31:18]}
              ^ (w_reg[1] >> 3);
    assign s1 = {w_reg[14][16:0], w_reg[14][31:17]} ^ {w_reg[14][18:0], w_reg[14][31:19]}
              ^ (w_reg[14] >> 10);
    assign w_new = w_reg[0] + s0 + w_reg[9] + s1;
    assign w_cur = (round_reg < 6'd16) ? rd_word_reg : w_new;

    // Round function.
    assign e  = v_reg[4];
    assign a  = v_reg[0];
    assign t1 = v_reg[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
              + ((e & v_reg[5]) ^ (~e & v_reg[6])) + ROUND_K[round_reg] + w_cur;
    assign t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
              + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    // Schedule window and working variables.
    always_ff @(posedge clk)
    begin
        if (cmd.comp_start)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_reg[i];
            end
        end
        else if (cmd.comp_round)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= w_cur;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= e;
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= a;
            v_reg[0] <= t1 + t2;
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_item.digest_word  <= h_reg[cmd.out_index];
            out_item.word_number  <= cmd.out_index;
            out_item.last_word    <= (cmd.out_index == 3'd7);
            out_item.len_overflow <= too_long_reg;
        end
    end

    // Control-side state: hash words, counters, fill pointer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= INITIAL_H[i];
            end
            count_reg    <= '0;
            too_long_reg <= 1'b0;
            fill_reg     <= '0;
            round_reg    <= '0;
        end
        else
        begin
            if (cmd.restart)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= INITIAL_H[i];
                end
                count_reg    <= '0;
                too_long_reg <= 1'b0;
                fill_reg     <= '0;
            end
            else
            begin
                if (cmd.comp_fold)
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    end
                end
                if (cmd.wr_byte)
                begin
                    fill_reg <= fill_reg + 6'd1;
                end
                if (cmd.count_byte)
                begin
                    if (count_reg == MAX_BYTES)
                    begin
                        too_long_reg <= 1'b1;
                    end
                    else
                    begin
                        count_reg <= count_reg + 61'd1;
                    end
                end
            end
            if (cmd.comp_start)
            begin
                round_reg <= '0;
            end
            else if (cmd.comp_round)
            begin
                round_reg <= round_reg + 6'd1;
            end
        end
    end
endmodule
`default_nettype wire

[rtl/shs_controller.sv]
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte intake, padding, compression and digest output.
// ----------------------------------------------------------------------------
`default_nettype none
module shs_controller (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             in_byte_valid,
    input  wire logic             in_end,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    input  shs_pkg::shs_status_t  status,
    output shs_pkg::shs_cmd_t     cmd
);
    import shs_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_START = 3'd2;
    localparam logic [2:0] ST_ROUND = 3'd3;
    localparam logic [2:0] ST_FOLD  = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       fin_reg, fin_next;     // finishing the message
    logic       len_reg, len_next;     // length goes in the current block
    logic       padw_reg, padw_next;   // 0x80 already written
    logic [2:0] oidx_reg, oidx_next;
    logic       ov_reg, ov_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        fin_next   = fin_reg;
        len_next   = len_reg;
        padw_next  = padw_reg;
        oidx_next  = oidx_reg;
        ov_next    = ov_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_byte_valid)
                    begin
                        cmd.wr_byte    = 1'b1;
                        cmd.byte_sel   = BSEL_DATA;
                        cmd.count_byte = 1'b1;
                    end
                    fin_next  = in_end;
                    padw_next = 1'b0;
                    len_next  = 1'b0;
                    if (in_byte_valid && status.fill_level == 6'd63)
                    begin
                        state_next = ST_START;
                    end
                    else if (in_end)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                cmd.wr_byte = 1'b1;
                if (!padw_reg)
                begin
                    // The length fits in this block only if 0x80 lands before it.
                    cmd.byte_sel = BSEL_PAD;
                    padw_next    = 1'b1;
                    len_next     = (status.fill_level < LEN_START);
                end
                else if (len_reg && status.fill_level >= LEN_START)
                begin
                    cmd.byte_sel = BSEL_LEN;
                end
                else
                begin
                    cmd.byte_sel = BSEL_ZERO;
                end
                if (status.fill_level == 6'd63)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                cmd.comp_start = 1'b1;
                state_next     = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.comp_round = 1'b1;
                if (status.round_index == 6'd63)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                cmd.comp_fold = 1'b1;
                if (!fin_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (padw_reg && len_reg)
                begin
                    oidx_next  = 3'd0;
                    state_next = ST_OUT;
                end
                else
                begin
                    // A second padding block carries the length.
                    if (padw_reg)
                    begin
                        len_next = 1'b1;
                    end
                    state_next = ST_PAD;
                end
            end
            ST_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.out_index = oidx_reg;
                    ov_next       = 1'b1;
                    oidx_next     = oidx_reg + 3'd1;
                    if (oidx_reg == 3'd7)
                    begin
                        cmd.restart = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (ov_reg && out_ready && !cmd.out_load)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fin_reg   <= 1'b0;
            len_reg   <= 1'b0;
            padw_reg  <= 1'b0;
            oidx_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
            len_reg   <= len_next;
            padw_reg  <= padw_next;
            oidx_reg  <= oidx_next;
            ov_reg    <= ov_next;
        end
    end
endmodule
`default_nettype wire

[rtl/sha256_stream_hasher_top.sv]
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Channel   Dir   Payload
// in_ch     sink  data_byte, byte_valid, end_of_message
// out_ch    src   digest_word, word_number, last_word, len_overflow
//
// A byte item is written into the block buffer; the 64th byte of a block adds a load step,
// 64 rounds and a fold step of the single round unit.
// An end mark writes the padding one byte a cycle, runs one or two
// compressions and then issues eight words through the output register.
// Input is not taken while padding, compressing or issuing words.
// Reset is asynchronous and restores the initial hash values.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_stream_hasher_top (
    input  wire logic clk,
    input  wire logic rst_n,
    shs_stream_if.sink   in_ch,
    shs_stream_if.source out_ch
);
    import shs_pkg::*;

    shs_cmd_t    cmd;
    shs_status_t status;
    in_item_t    in_item;
    out_item_t   out_item;

    assign in_item        = in_ch.payload;
    assign out_ch.payload = out_item;

    shs_controller u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_ch.valid),
        .in_byte_valid (in_item.byte_valid),
        .in_end        (in_item.end_of_message),
        .in_ready      (in_ch.ready),
        .out_valid     (out_ch.valid),
        .out_ready     (out_ch.ready),
        .status        (status),
        .cmd           (cmd)
    );

    shs_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_byte (in_item.data_byte),
        .cmd       (cmd),
        .status    (status),
        .out_item  (out_item)
    );
endmodule
`default_nettype wire

[rtl/shs_checker.sv]
// ----------------------------------------------------------------------------
// SHA-256 stream hasher checker
// Port-level properties of the hasher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sha256_stream_hasher_top_macros.svh"
module shs_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic [2:0] word_number,
    input wire logic last_word
);
    `SHS_ASSERT_IMP(a_last_is_seven, clk, rst_n, out_valid, last_word == (word_number == 3'd7), "last_word mismatch")
    `SHS_ASSERT_IMP(a_no_in_during_out, clk, rst_n, out_valid && !last_word, !in_ready, "input taken during digest")
    `SHS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(word_number), "word dropped")
    `SHS_ASSERT_NEXT(a_word_order, clk, rst_n, out_valid && out_ready && !last_word, out_valid && word_number == $past(word_number) + 3'd1, "word order")
endmodule

bind sha256_stream_hasher_top shs_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .word_number (out_ch.payload.word_number),
    .last_word   (out_ch.payload.last_word)
);
`default_nettype wire
